>>> src/ias_pkg.sv
// types, constants and a helper function for the interval activation scheduler
// used by every other file of the block; depends on nothing
`timescale 1ns / 1ps

package ias_pkg;

  localparam int MAX_INTERVALS = 32;
  localparam int IDX_W = $clog2(MAX_INTERVALS);
  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam int TIME_W = 63;
  localparam int NEXT_W = 64;
  localparam int STEP_W = 33;
  localparam int ID_W = 8;
  localparam int KIND_W = 3;
  localparam int CMD_W = 2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_EXPIRED  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_STARTED  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SUMMARY  = 3'd4;

  localparam logic REG_MIN_STEP = 1'b0;
  localparam logic REG_MAX_STEP = 1'b1;

  localparam logic [NEXT_W-1:0] NONE_PENDING = '1;
  localparam logic [NEXT_W-1:0] TIME_LIMIT   = {1'b0, {TIME_W{1'b1}}};
  localparam logic [STEP_W-1:0] STEP_OFF     = '1;

  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic [ID_W-1:0]   id;
  } upc_entry_t;

  typedef struct packed {
    logic [TIME_W-1:0] end_time;
    logic [ID_W-1:0]   id;
  } act_entry_t;

  typedef struct packed {
    logic       u_we;
    idx_t       u_wa;
    upc_entry_t u_wd;
    logic       u_re;
    idx_t       u_ra;
    logic       a_we;
    idx_t       a_wa;
    act_entry_t a_wd;
    logic       a_re;
    idx_t       a_ra;
  } mem_req_t;

  typedef struct packed {
    cnt_t ucnt;
    cnt_t acnt;
  } occ_t;

  // slot at a given offset from the head of a circular store
  function automatic idx_t idx_add(idx_t base, cnt_t off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(MAX_INTERVALS)) begin
      sum = sum - (CNT_W+1)'(MAX_INTERVALS);
    end
    return idx_t'(sum);
  endfunction

endpackage

>>> src/ias_if.sv
// request, result and configuration channels of the interval scheduler
// depends on ias_pkg
`timescale 1ns / 1ps

interface ias_req_if;
  import ias_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [ID_W-1:0]     interval_id;
  logic [TIME_W-1:0]   start_time;
  logic [TIME_W-1:0]   end_time;
  logic [TIME_W-1:0]   now;
  modport source (output valid, cmd, interval_id, start_time, end_time, now, input ready);
  modport sink (input valid, cmd, interval_id, start_time, end_time, now, output ready);
endinterface

interface ias_res_if;
  import ias_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [ID_W-1:0]          changed_id;
  logic signed [NEXT_W-1:0] next_change;
  logic                     last;
  modport source (output valid, kind, changed_id, next_change, last, input ready);
  modport sink (input valid, kind, changed_id, next_change, last, output ready);
endinterface

interface ias_cfg_if;
  import ias_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     index;
  logic signed [STEP_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/ias_stores.sv
// upcoming and active stores: one write and one registered read port each
// depends on ias_pkg
`timescale 1ns / 1ps

module ias_stores (
  input  logic                clk,
  input  ias_pkg::mem_req_t   req,
  output ias_pkg::upc_entry_t u_rdata,
  output ias_pkg::act_entry_t a_rdata
);
  import ias_pkg::*;

  upc_entry_t umem [MAX_INTERVALS];
  act_entry_t amem [MAX_INTERVALS];

  always_ff @(posedge clk) begin
    if (req.u_we) begin
      umem[req.u_wa] <= req.u_wd;
    end
    if (req.u_re) begin
      u_rdata <= umem[req.u_ra];
    end
    if (req.a_we) begin
      amem[req.a_wa] <= req.a_wd;
    end
    if (req.a_re) begin
      a_rdata <= amem[req.a_ra];
    end
  end

endmodule

>>> src/ias_ctrl.sv
// command sequencer: sorted insertion, expiry, start and summary over the stores
// depends on ias_pkg and ias_if; drives ias_stores
`timescale 1ns / 1ps

module ias_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  ias_req_if.sink                   requests,
  ias_res_if.source                 results,
  input  logic [ias_pkg::STEP_W-1:0] min_step,
  input  logic [ias_pkg::STEP_W-1:0] max_step,
  output ias_pkg::mem_req_t         mem_req,
  input  ias_pkg::upc_entry_t       u_rdata,
  input  ias_pkg::act_entry_t       a_rdata,
  output ias_pkg::occ_t             occ
);
  import ias_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_ADD_CHK  = 5'd1;
  localparam logic [4:0] S_UINS_RD  = 5'd2;
  localparam logic [4:0] S_UINS_CMP = 5'd3;
  localparam logic [4:0] S_ADD_EMIT = 5'd4;
  localparam logic [4:0] S_EXP_RD   = 5'd5;
  localparam logic [4:0] S_EXP_CHK  = 5'd6;
  localparam logic [4:0] S_STA_RD   = 5'd7;
  localparam logic [4:0] S_STA_CHK  = 5'd8;
  localparam logic [4:0] S_AINS_RD  = 5'd9;
  localparam logic [4:0] S_AINS_CMP = 5'd10;
  localparam logic [4:0] S_STA_EMIT = 5'd11;
  localparam logic [4:0] S_SUM_RD   = 5'd12;
  localparam logic [4:0] S_SUM_MIN  = 5'd13;
  localparam logic [4:0] S_SUM_LO   = 5'd14;
  localparam logic [4:0] S_SUM_HI   = 5'd15;
  localparam logic [4:0] S_SUM_EMIT = 5'd16;

  logic [4:0] state, state_next;
  logic [CMD_W-1:0] c_cmd, c_cmd_next;
  logic [ID_W-1:0] c_id, c_id_next;
  logic [TIME_W-1:0] c_start, c_start_next;
  logic [TIME_W-1:0] c_end, c_end_next;
  logic [TIME_W-1:0] c_now, c_now_next;
  idx_t uhd, uhd_next, ahd, ahd_next;
  cnt_t ucnt, ucnt_next, acnt, acnt_next;
  cnt_t pos, pos_next;
  logic [TIME_W-1:0] ins_key, ins_key_next;
  logic [ID_W-1:0] ins_id, ins_id_next;
  logic [KIND_W-1:0] add_kind, add_kind_next;
  logic [NEXT_W-1:0] nxt, nxt_next;

  logic ovalid, ovalid_next;
  logic [KIND_W-1:0] okind, okind_next;
  logic [ID_W-1:0] oid, oid_next;
  logic [NEXT_W-1:0] onext, onext_next;
  logic olast, olast_next;

  logic emit;
  logic [KIND_W-1:0] e_kind;
  logic [ID_W-1:0] e_id;
  logic [NEXT_W-1:0] e_next;
  logic e_last;
  logic can_emit;
  logic [CNT_W:0] total;
  logic [NEXT_W-1:0] lim_lo, lim_hi;

  assign can_emit = !ovalid || results.ready;
  assign total = (CNT_W+1)'(ucnt) + (CNT_W+1)'(acnt);
  assign lim_lo = {1'b0, c_now} + {{(NEXT_W-32){1'b0}}, min_step[31:0]};
  assign lim_hi = {1'b0, c_now} + {{(NEXT_W-32){1'b0}}, max_step[31:0]};

  assign requests.ready = (state == S_IDLE);
  assign results.valid = ovalid;
  assign results.kind = okind;
  assign results.changed_id = oid;
  assign results.next_change = onext;
  assign results.last = olast;
  assign occ.ucnt = ucnt;
  assign occ.acnt = acnt;

  always_comb begin
    state_next = state;
    c_cmd_next = c_cmd;
    c_id_next = c_id;
    c_start_next = c_start;
    c_end_next = c_end;
    c_now_next = c_now;
    uhd_next = uhd;
    ahd_next = ahd;
    ucnt_next = ucnt;
    acnt_next = acnt;
    pos_next = pos;
    ins_key_next = ins_key;
    ins_id_next = ins_id;
    add_kind_next = add_kind;
    nxt_next = nxt;
    mem_req = '0;
    emit = 1'b0;
    e_kind = KIND_SUMMARY;
    e_id = '0;
    e_next = '0;
    e_last = 1'b0;
    case (state)
      S_IDLE: begin
        if (requests.valid) begin
          c_cmd_next = requests.cmd;
          c_id_next = requests.interval_id;
          c_start_next = requests.start_time;
          c_end_next = requests.end_time;
          c_now_next = requests.now;
          case (requests.cmd)
            CMD_ADD: state_next = S_ADD_CHK;
            CMD_ADVANCE: state_next = S_EXP_RD;
            CMD_QUERY: state_next = S_SUM_RD;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_ADD_CHK: begin
        if (total >= (CNT_W+1)'(MAX_INTERVALS)) begin
          add_kind_next = KIND_REJECTED;
          state_next = S_ADD_EMIT;
        end else begin
          add_kind_next = KIND_ACCEPTED;
          pos_next = ucnt;
          state_next = S_UINS_RD;
        end
      end
      S_UINS_RD: begin
        if (pos == '0) begin
          mem_req.u_we = 1'b1;
          mem_req.u_wa = uhd;
          mem_req.u_wd = '{start_time: c_start, end_time: c_end, id: c_id};
          ucnt_next = ucnt + 1'b1;
          state_next = S_ADD_EMIT;
        end else begin
          mem_req.u_re = 1'b1;
          mem_req.u_ra = idx_add(uhd, pos - 1'b1);
          state_next = S_UINS_CMP;
        end
      end
      S_UINS_CMP: begin
        mem_req.u_we = 1'b1;
        mem_req.u_wa = idx_add(uhd, pos);
        if (u_rdata.start_time > c_start) begin
          mem_req.u_wd = u_rdata;
          pos_next = pos - 1'b1;
          state_next = S_UINS_RD;
        end else begin
          mem_req.u_wd = '{start_time: c_start, end_time: c_end, id: c_id};
          ucnt_next = ucnt + 1'b1;
          state_next = S_ADD_EMIT;
        end
      end
      S_ADD_EMIT: begin
        if (can_emit) begin
          emit = 1'b1;
          e_kind = add_kind;
          e_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EXP_RD: begin
        if (acnt == '0) begin
          state_next = S_STA_RD;
        end else begin
          mem_req.a_re = 1'b1;
          mem_req.a_ra = ahd;
          state_next = S_EXP_CHK;
        end
      end
      S_EXP_CHK: begin
        if (a_rdata.end_time <= c_now) begin
          if (can_emit) begin
            emit = 1'b1;
            e_kind = KIND_EXPIRED;
            e_id = a_rdata.id;
            ahd_next = idx_add(ahd, cnt_t'(1));
            acnt_next = acnt - 1'b1;
            state_next = S_EXP_RD;
          end
        end else begin
          state_next = S_STA_RD;
        end
      end
      S_STA_RD: begin
        if (ucnt == '0) begin
          state_next = S_SUM_RD;
        end else begin
          mem_req.u_re = 1'b1;
          mem_req.u_ra = uhd;
          state_next = S_STA_CHK;
        end
      end
      S_STA_CHK: begin
        if (u_rdata.start_time <= c_now) begin
          ins_key_next = u_rdata.end_time;
          ins_id_next = u_rdata.id;
          uhd_next = idx_add(uhd, cnt_t'(1));
          ucnt_next = ucnt - 1'b1;
          pos_next = acnt;
          state_next = S_AINS_RD;
        end else begin
          state_next = S_SUM_RD;
        end
      end
      S_AINS_RD: begin
        if (pos == '0) begin
          mem_req.a_we = 1'b1;
          mem_req.a_wa = ahd;
          mem_req.a_wd = '{end_time: ins_key, id: ins_id};
          acnt_next = acnt + 1'b1;
          state_next = S_STA_EMIT;
        end else begin
          mem_req.a_re = 1'b1;
          mem_req.a_ra = idx_add(ahd, pos - 1'b1);
          state_next = S_AINS_CMP;
        end
      end
      S_AINS_CMP: begin
        mem_req.a_we = 1'b1;
        mem_req.a_wa = idx_add(ahd, pos);
        if (a_rdata.end_time > ins_key) begin
          mem_req.a_wd = a_rdata;
          pos_next = pos - 1'b1;
          state_next = S_AINS_RD;
        end else begin
          mem_req.a_wd = '{end_time: ins_key, id: ins_id};
          acnt_next = acnt + 1'b1;
          state_next = S_STA_EMIT;
        end
      end
      S_STA_EMIT: begin
        if (can_emit) begin
          emit = 1'b1;
          e_kind = KIND_STARTED;
          e_id = ins_id;
          state_next = S_STA_RD;
        end
      end
      S_SUM_RD: begin
        mem_req.u_re = 1'b1;
        mem_req.u_ra = uhd;
        mem_req.a_re = 1'b1;
        mem_req.a_ra = ahd;
        state_next = S_SUM_MIN;
      end
      S_SUM_MIN: begin
        state_next = S_SUM_LO;
        if (acnt == '0 && ucnt == '0) begin
          nxt_next = NONE_PENDING;
          state_next = S_SUM_EMIT;
        end else if (acnt == '0) begin
          nxt_next = {1'b0, u_rdata.start_time};
        end else if (ucnt == '0) begin
          nxt_next = {1'b0, a_rdata.end_time};
        end else if (a_rdata.end_time < u_rdata.start_time) begin
          nxt_next = {1'b0, a_rdata.end_time};
        end else begin
          nxt_next = {1'b0, u_rdata.start_time};
        end
      end
      S_SUM_LO: begin
        if (!min_step[STEP_W-1]) begin
          if (lim_lo > TIME_LIMIT) begin
            if (TIME_LIMIT > nxt) nxt_next = TIME_LIMIT;
          end else if (lim_lo > nxt) begin
            nxt_next = lim_lo;
          end
        end
        state_next = S_SUM_HI;
      end
      S_SUM_HI: begin
        if (!max_step[STEP_W-1] && lim_hi < nxt) begin
          nxt_next = lim_hi;
        end
        state_next = S_SUM_EMIT;
      end
      S_SUM_EMIT: begin
        if (can_emit) begin
          emit = 1'b1;
          e_kind = KIND_SUMMARY;
          e_next = nxt;
          e_last = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ovalid_next = ovalid;
    okind_next = okind;
    oid_next = oid;
    onext_next = onext;
    olast_next = olast;
    if (ovalid && results.ready) begin
      ovalid_next = 1'b0;
    end
    if (emit) begin
      ovalid_next = 1'b1;
      okind_next = e_kind;
      oid_next = e_id;
      onext_next = e_next;
      olast_next = e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      uhd <= '0;
      ahd <= '0;
      ucnt <= '0;
      acnt <= '0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      uhd <= uhd_next;
      ahd <= ahd_next;
      ucnt <= ucnt_next;
      acnt <= acnt_next;
      ovalid <= ovalid_next;
    end
  end

  always_ff @(posedge clk) begin
    c_cmd <= c_cmd_next;
    c_id <= c_id_next;
    c_start <= c_start_next;
    c_end <= c_end_next;
    c_now <= c_now_next;
    pos <= pos_next;
    ins_key <= ins_key_next;
    ins_id <= ins_id_next;
    add_kind <= add_kind_next;
    nxt <= nxt_next;
    okind <= okind_next;
    oid <= oid_next;
    onext <= onext_next;
    olast <= olast_next;
  end

endmodule

>>> src/interval_activation_scheduler_unit.sv
// top level of the interval activation scheduler: step registers, sequencer, stores
// depends on ias_pkg, ias_if, ias_stores and ias_ctrl
`timescale 1ns / 1ps

// channel   | dir | carries
// requests  | in  | cmd, interval_id, start_time, end_time, now
// results   | out | kind, changed_id, next_change, last
// cfg       | in  | index (0 min_step, 1 max_step), data
//
// the sequencer reads the stores through their registered read ports
// add: rejected when both stores together are full, else upcoming entries with a later
// start shift one slot toward the tail and the new entry fills the gap; advance: expire
// active entries whose end is not after now, then start upcoming ones whose start is not
// after now, each sorted into the active store by end, then summarise; query: summary only
// reset clears both store counts and disables both steps; a stalled result holds the sequencer

module interval_activation_scheduler_unit (
  input logic       clk,
  input logic       rst,
  ias_req_if.sink   requests,
  ias_res_if.source results,
  ias_cfg_if.sink   cfg
);
  import ias_pkg::*;

  logic [STEP_W-1:0] min_step, max_step;
  mem_req_t mem_req;
  upc_entry_t u_rdata;
  act_entry_t a_rdata;
  occ_t occ;
  logic [CNT_W:0] total;

  assign cfg.ready = 1'b1;
  assign total = (CNT_W+1)'(occ.ucnt) + (CNT_W+1)'(occ.acnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_step <= STEP_OFF;
      max_step <= STEP_OFF;
    end else if (cfg.valid) begin
      if (cfg.index == REG_MIN_STEP) min_step <= cfg.data;
      if (cfg.index == REG_MAX_STEP) max_step <= cfg.data;
    end
  end

  ias_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .requests (requests),
    .results  (results),
    .min_step (min_step),
    .max_step (max_step),
    .mem_req  (mem_req),
    .u_rdata  (u_rdata),
    .a_rdata  (a_rdata),
    .occ      (occ)
  );

  ias_stores u_stores (
    .clk     (clk),
    .req     (mem_req),
    .u_rdata (u_rdata),
    .a_rdata (a_rdata)
  );

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    total <= (CNT_W+1)'(MAX_INTERVALS))
    else $error("store occupancy above capacity");

  a_occ_reset: assert property (@(posedge clk)
    rst |=> (occ.ucnt == '0 && occ.acnt == '0))
    else $error("store counts not cleared by reset");

  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (total == $past(total) || total == $past(total) + 1'b1
                     || total == $past(total) - 1'b1))
    else $error("occupancy moved by more than one entry");

endmodule

>>> tb/sv/ias_checker.sv
// checker for the interval activation scheduler: watches all three channels,
// keeps its own copy of both stores and the step registers, compares every result
// depends on ias_pkg and ias_if
`timescale 1ns / 1ps

module ias_checker
  import ias_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ias_req_if   requests,
  ias_res_if   results,
  ias_cfg_if   cfg,
  output int   errors,
  output int   pending
);

  typedef struct {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic [ID_W-1:0]   id;
  } waiting_t;

  typedef struct {
    logic [TIME_W-1:0] end_time;
    logic [ID_W-1:0]   id;
  } running_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   changed_id;
    logic [NEXT_W-1:0] next_change;
    logic              last;
  } outcome_t;

  waiting_t          waiting_q[$];
  running_t          running_q[$];
  outcome_t          outcome_q[$];
  logic [STEP_W-1:0] min_step;
  logic [STEP_W-1:0] max_step;

  assign pending = outcome_q.size();

  function automatic outcome_t mk(logic [KIND_W-1:0] k, logic [ID_W-1:0] id,
                                  logic [NEXT_W-1:0] nc);
    outcome_t o;
    o.kind = k;
    o.changed_id = id;
    o.next_change = nc;
    o.last = 1'b0;
    return o;
  endfunction

  function automatic void queue_outcome(ref outcome_t q[$], input outcome_t o);
    q.insert(q.size(), o);
  endfunction

  function automatic logic [NEXT_W-1:0] next_change_after(logic [TIME_W-1:0] t);
    logic [NEXT_W-1:0] nxt;
    logic [NEXT_W-1:0] lim;
    if (running_q.size() == 0 && waiting_q.size() == 0) return NONE_PENDING;
    if (running_q.size() == 0) nxt = {1'b0, waiting_q[0].start_time};
    else if (waiting_q.size() == 0) nxt = {1'b0, running_q[0].end_time};
    else if (running_q[0].end_time < waiting_q[0].start_time)
      nxt = {1'b0, running_q[0].end_time};
    else nxt = {1'b0, waiting_q[0].start_time};
    if (!min_step[STEP_W-1]) begin
      lim = {1'b0, t} + {32'd0, min_step[31:0]};
      if (lim > TIME_LIMIT) lim = TIME_LIMIT;
      if (lim > nxt) nxt = lim;
    end
    if (!max_step[STEP_W-1]) begin
      lim = {1'b0, t} + {32'd0, max_step[31:0]};
      if (lim < nxt) nxt = lim;
    end
    return nxt;
  endfunction

  task automatic schedule_request();
    outcome_t  batch[$];
    waiting_t  w;
    running_t  r;
    int        p;
    case (requests.cmd)
      CMD_ADD: begin
        if (waiting_q.size() + running_q.size() >= MAX_INTERVALS) begin
          queue_outcome(batch, mk(KIND_REJECTED, '0, '0));
        end else begin
          w.start_time = requests.start_time;
          w.end_time = requests.end_time;
          w.id = requests.interval_id;
          p = 0;
          while (p < waiting_q.size() && waiting_q[p].start_time <= w.start_time) p++;
          waiting_q.insert(p, w);
          queue_outcome(batch, mk(KIND_ACCEPTED, '0, '0));
        end
      end
      CMD_ADVANCE: begin
        while (running_q.size() > 0 && running_q[0].end_time <= requests.now) begin
          queue_outcome(batch, mk(KIND_EXPIRED, running_q[0].id, '0));
          void'(running_q.pop_front());
        end
        while (waiting_q.size() > 0 && waiting_q[0].start_time <= requests.now) begin
          w = waiting_q.pop_front();
          r.end_time = w.end_time;
          r.id = w.id;
          p = 0;
          while (p < running_q.size() && running_q[p].end_time <= r.end_time) p++;
          running_q.insert(p, r);
          queue_outcome(batch, mk(KIND_STARTED, w.id, '0));
        end
        queue_outcome(batch, mk(KIND_SUMMARY, '0, next_change_after(requests.now)));
      end
      CMD_QUERY: queue_outcome(batch, mk(KIND_SUMMARY, '0, next_change_after(requests.now)));
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) queue_outcome(outcome_q, batch[i]);
  endtask

  task automatic compare_result();
    outcome_t o;
    if (outcome_q.size() == 0) begin
      $error("result with nothing expected: kind %0d", results.kind);
      errors++;
    end else begin
      o = outcome_q.pop_front();
      if (results.kind !== o.kind) begin
        $error("kind: expected %0d, actual %0d", o.kind, results.kind);
        errors++;
      end
      if (results.changed_id !== o.changed_id) begin
        $error("changed_id: expected %0d, actual %0d", o.changed_id, results.changed_id);
        errors++;
      end
      if (results.next_change !== o.next_change) begin
        $error("next_change: expected %0d, actual %0d", $signed(o.next_change),
               results.next_change);
        errors++;
      end
      if (results.last !== o.last) begin
        $error("last: expected %0d, actual %0d", o.last, results.last);
        errors++;
      end
    end
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    if (rst) begin
      waiting_q.delete();
      running_q.delete();
      outcome_q.delete();
      min_step = STEP_OFF;
      max_step = STEP_OFF;
    end else begin
      if (results.valid && results.ready) compare_result();
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_MIN_STEP) min_step = cfg.data;
        else max_step = cfg.data;
      end
      if (requests.valid && requests.ready) schedule_request();
    end
  end

endmodule

>>> tb/sv/tb_interval_activation_scheduler_unit.sv
// testbench top for the interval activation scheduler: clock, reset, requests,
// step settings and result stalls; verdict from the checker's failure count
// depends on ias_pkg, ias_if, ias_checker and the block itself
`timescale 1ns / 1ps

module tb_interval_activation_scheduler_unit;
  import ias_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [TIME_W-1:0] TMAX = '1;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic quiet = 1'b0;
  int   errors;
  int   pending;
  int   cycles = 0;
  logic [TIME_W-1:0] clock_now = '0;

  ias_req_if requests();
  ias_res_if results();
  ias_cfg_if cfg();

  interval_activation_scheduler_unit i_dut (
    .clk(clk), .rst(rst), .requests(requests), .results(results), .cfg(cfg)
  );

  ias_checker i_checker (
    .clk(clk), .rst(rst), .requests(requests), .results(results), .cfg(cfg),
    .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result stalls
  always @(posedge clk) begin
    results.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 34);
  end

  initial begin
    requests.valid = 1'b0;
    requests.cmd = CMD_QUERY;
    requests.interval_id = '0;
    requests.start_time = '0;
    requests.end_time = '0;
    requests.now = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_MIN_STEP;
    cfg.data = '0;
  end

  task automatic send(logic [CMD_W-1:0] c, logic [ID_W-1:0] id,
                      logic [TIME_W-1:0] s, logic [TIME_W-1:0] e, logic [TIME_W-1:0] t);
    if (!quiet && $urandom_range(99) < 34) begin
      requests.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    requests.valid <= 1'b1;
    requests.cmd <= c;
    requests.interval_id <= id;
    requests.start_time <= s;
    requests.end_time <= e;
    requests.now <= t;
    @(posedge clk);
    while (!requests.ready) @(posedge clk);
  endtask

  task automatic settle();
    requests.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_step(logic idx, logic [STEP_W-1:0] d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= d;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom, $urandom} >> 1);
  endfunction

  task automatic random_request();
    int                sel;
    logic [TIME_W-1:0] s;
    logic [TIME_W-1:0] e;
    logic [TIME_W-1:0] t;
    sel = $urandom_range(99);
    s = clock_now + $urandom_range(0, 40);
    e = s + $urandom_range(0, 40);
    if ($urandom_range(9) == 0) e = clock_now + $urandom_range(0, 10);
    if ($urandom_range(19) == 0) s = rand_time();
    if ($urandom_range(19) == 0) e = rand_time();
    if (sel < 50) begin
      send(CMD_ADD, 8'($urandom), s, e, rand_time());
    end else if (sel < 85) begin
      if ($urandom_range(49) == 0) t = TMAX - $urandom_range(0, 3);
      else if ($urandom_range(9) == 0 && clock_now > 20) t = clock_now - $urandom_range(0, 20);
      else t = clock_now + $urandom_range(0, 15);
      if (t > clock_now && t < (TMAX >> 1)) clock_now = t;
      send(CMD_ADVANCE, 8'($urandom), rand_time(), rand_time(), t);
    end else if (sel < 97) begin
      send(CMD_QUERY, 8'($urandom), rand_time(), rand_time(),
           ($urandom_range(9) == 0) ? rand_time() : clock_now + $urandom_range(0, 15));
    end else begin
      send(CMD_UNUSED, 8'($urandom), rand_time(), rand_time(), rand_time());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every command, corner cases
    send(CMD_QUERY, '0, '0, '0, '0);
    send(CMD_ADD, 8'hff, TMAX, TMAX, '0);
    send(CMD_ADD, 8'h00, '0, '0, '0);
    send(CMD_ADD, 8'h11, 63'd20, 63'd5, '0);
    send(CMD_ADD, 8'h11, 63'd20, 63'd30, '0);
    send(CMD_ADD, 8'h22, 63'd20, 63'd30, '0);
    send(CMD_UNUSED, 8'hff, TMAX, TMAX, TMAX);
    send(CMD_QUERY, '0, '0, '0, 63'd3);
    send(CMD_ADVANCE, '0, '0, '0, 63'd0);
    send(CMD_ADVANCE, '0, '0, '0, 63'd25);
    send(CMD_ADVANCE, '0, '0, '0, 63'd30);
    send(CMD_ADVANCE, '0, '0, '0, TMAX);
    send(CMD_ADVANCE, '0, '0, '0, TMAX);
    send(CMD_QUERY, '0, '0, '0, TMAX);
    settle();

    write_step(REG_MIN_STEP, 33'd3);
    write_step(REG_MAX_STEP, 33'd10);
    send(CMD_ADD, 8'h5a, TMAX - 1, TMAX, '0);
    send(CMD_QUERY, '0, '0, '0, TMAX - 1);
    send(CMD_QUERY, '0, '0, '0, '0);
    send(CMD_ADVANCE, '0, '0, '0, TMAX);
    send(CMD_QUERY, '0, '0, '0, 63'd7);
    settle();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin write_step(REG_MIN_STEP, STEP_OFF); write_step(REG_MAX_STEP, STEP_OFF); end
        1: begin write_step(REG_MIN_STEP, 33'd0); write_step(REG_MAX_STEP, 33'hffffffff); end
        2: begin write_step(REG_MIN_STEP, 33'hffffffff); write_step(REG_MAX_STEP, 33'd0); end
        3: begin write_step(REG_MIN_STEP, 33'd2); write_step(REG_MAX_STEP, 33'd12); end
        default: begin
          write_step(REG_MIN_STEP, 33'h155555555);
          write_step(REG_MAX_STEP, 33'h0aaaaaaaa);
        end
      endcase
      for (int n = 0; n < 60; n++) begin
        quiet = (phase == 2 && n >= 10 && n < 45);
        random_request();
      end
      quiet = 1'b0;
      settle();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
src/ias_pkg.sv
src/ias_if.sv
src/ias_stores.sv
src/ias_ctrl.sv
src/interval_activation_scheduler_unit.sv
tb/sv/ias_checker.sv
tb/sv/tb_interval_activation_scheduler_unit.sv
